FILE: sv/min_contrast_color_adjust_assert.svh
// Assertion macros for the minimum-contrast color adjuster.
`ifndef MIN_CONTRAST_COLOR_ADJUST_ASSERT_SVH
`define MIN_CONTRAST_COLOR_ADJUST_ASSERT_SVH
`ifndef SYNTH
`define MCCA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define MCCA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define MCCA_ASSERT_IMP(lbl, ante, cons)
`define MCCA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: sv/mcca_pkg.sv
// Package with types and constants for the minimum-contrast color adjuster.
package mcca_pkg;

  localparam int SEARCH_STEPS_DEF = 24;
  localparam int CHANNEL_BITS_DEF = 12;
  localparam int LUMA_BITS_DEF    = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int RATIO_W    = 13;
  localparam int COEF_W     = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATIO     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_BACKDROP = 2'd1;

  localparam logic [RATIO_W-1:0] MIN_RATIO_RST = 13'd1152;

  localparam logic [COEF_W-1:0] COEF_RED   = 13'd2126;
  localparam logic [COEF_W-1:0] COEF_GREEN = 13'd7152;
  localparam logic [COEF_W-1:0] COEF_BLUE  = 13'd722;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LUM_RD,
    S_LUM_MUL,
    S_LUM_ACC,
    S_RAT_MUL,
    S_RAT_CMP,
    S_CMP_MUL,
    S_CMP_SUM,
    S_CMP_DIV,
    S_CMP_FIX,
    S_MIX_MUL,
    S_MIX_FIX,
    S_OUT_SUM,
    S_OUT_DIV,
    S_OUT_FIX
  } state_t;

  typedef enum logic [2:0] {
    PH_BG,
    PH_FG,
    PH_EFF,
    PH_SRCH,
    PH_FINAL
  } phase_t;

  function automatic logic [COEF_W-1:0] luma_coef(input logic [1:0] ch);
    logic [COEF_W-1:0] c;
    unique case (ch)
      2'd0:    c = COEF_RED;
      2'd1:    c = COEF_GREEN;
      2'd2:    c = COEF_BLUE;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/min_contrast_color_adjust.sv
// Minimum-contrast color adjuster: sequencer around one shared multiplier.
//
// Usage: present both colors on the in_ ports and raise start while busy is
// low; the transaction is taken at that edge and busy rises. The result shows
// on the out_ ports for exactly one cycle with out_valid, and busy is low in
// that same cycle, so the next start may be taken there.
// Configuration goes through cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready
// is always high, write only while busy is low.
// Each luminance is a ROM read, a multiply and an accumulate per
// channel, and every ratio test runs on the shared multiplier.
// A passing foreground returns after both luminances and one ratio test. A
// failing one runs the composite and the target luminance, then SEARCH_STEPS
// bisection steps (3-channel mix, luminance, ratio test), a final test and
// output rounding; an opaque background skips the composite, and a fallback
// skips the output rounding.
// The linearization ROM (2^CHANNEL_BITS entries) has one read port, which
// together with the single multiplier sets the step length.
// Reset (rst_n low, synchronous) returns to idle, min_ratio 1152, white
// backdrop. The receiver cannot stall: results are never held back.
`include "min_contrast_color_adjust_assert.svh"
module min_contrast_color_adjust #(
  parameter int SEARCH_STEPS = mcca_pkg::SEARCH_STEPS_DEF,
  parameter int CHANNEL_BITS = mcca_pkg::CHANNEL_BITS_DEF,
  parameter int LUMA_BITS    = mcca_pkg::LUMA_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [7:0]                       in_fg_red,
  input  logic [7:0]                       in_fg_green,
  input  logic [7:0]                       in_fg_blue,
  input  logic [7:0]                       in_fg_alpha,
  input  logic [7:0]                       in_bg_red,
  input  logic [7:0]                       in_bg_green,
  input  logic [7:0]                       in_bg_blue,
  input  logic [7:0]                       in_bg_alpha,
  output logic                             out_valid,
  output logic [7:0]                       out_red,
  output logic [7:0]                       out_green,
  output logic [7:0]                       out_blue,
  output logic [7:0]                       out_alpha,
  output logic                             out_adjusted,
  output logic                             out_fell_back,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mcca_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcca_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int C      = CHANNEL_BITS;
  localparam int L      = LUMA_BITS;
  localparam int SS     = SEARCH_STEPS;
  localparam int TAB_N  = 1 << C;
  localparam int YW     = L + 14;
  localparam int NW     = C + 8;
  localparam int DS     = C + 8;
  localparam int MIXW   = C + SS + 1;
  localparam int STEP_W = $clog2(SS);
  localparam int A_W0   = (SS + 1 > YW) ? SS + 1 : YW;
  localparam int A_W    = (A_W0 > NW) ? A_W0 : NW;
  localparam int B_W    = (C + 1 > mcca_pkg::RATIO_W) ? C + 1 : mcca_pkg::RATIO_W;
  localparam int P_W    = A_W + B_W;

  localparam longint unsigned CMAX = (64'd1 << C) - 64'd1;
  localparam longint unsigned LMAX = (64'd1 << L) - 64'd1;
  localparam longint unsigned QONE = 64'd1 << 30;

  localparam logic [SS:0]     W_FULL  = {1'b1, {SS{1'b0}}};
  localparam logic [MIXW-1:0] HALF_W  = MIXW'(W_FULL >> 1);
  localparam logic [YW-1:0]   Y_OFS   = YW'(64'd500 * LMAX);
  localparam logic [YW-1:0]   Y_THR   = YW'(64'd1790 * LMAX);
  localparam logic [B_W-1:0]  R_255   = B_W'((64'd1 << DS) / 64'd255);
  localparam logic [B_W-1:0]  R_CMAX  = B_W'((64'd1 << DS) / CMAX);
  localparam logic [C-1:0]    C_MAX   = C'(CMAX);
  localparam logic [NW-1:0]   C_HALF  = NW'(CMAX >> 1);

  typedef logic [L-1:0] lin_tab_t [TAB_N];
  typedef logic [C-1:0] exp_tab_t [256];

  function automatic longint unsigned const_div(input longint unsigned num,
                                                input longint unsigned dvs);
    longint unsigned q, r;
    q = 64'd0;
    r = 64'd0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], num[k]};
      q = q << 1;
      if (r >= dvs) begin
        r = r - dvs;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t tab;
    longint unsigned v, t, t2, lo, hi, mid, r2, r4;
    for (int i = 0; i < TAB_N; i++) begin
      v = 64'(i);
      if (v * 64'd100000 <= 64'd3928 * CMAX) begin
        tab[i] = L'(const_div(v * 64'd100 * LMAX, 64'd1292 * CMAX));
      end else begin
        t = const_div((64'd1000 * v + 64'd55 * CMAX) << 30, 64'd1055 * CMAX);
        if (t > QONE) begin
          t = QONE;
        end
        t2 = (t * t) >> 30;
        lo = 64'd0;
        hi = QONE + 64'd1;
        for (int k = 0; k < 32; k++) begin
          if (hi - lo > 64'd1) begin
            mid = lo + ((hi - lo) >> 1);
            r2 = (mid * mid) >> 30;
            r4 = (r2 * r2) >> 30;
            if (((r4 * mid) >> 30) <= t2) begin
              lo = mid;
            end else begin
              hi = mid;
            end
          end
        end
        tab[i] = L'((((t2 * lo) >> 30) * LMAX) >> 30);
      end
    end
    return tab;
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = C'(const_div(64'(i) * CMAX + 64'd127, 64'd255));
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_ROM = build_lin_tab();
  localparam exp_tab_t EXP_TAB = build_exp_tab();

  mcca_pkg::state_t state_r, state_nxt;
  mcca_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]        ch_r, ch_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [mcca_pkg::RATIO_W-1:0] min_ratio_r, min_ratio_nxt;
  logic              dark_r, dark_nxt;

  logic [C-1:0]  fg_r [4];
  logic [C-1:0]  fg_nxt [4];
  logic [7:0]    fgraw_r [4];
  logic [7:0]    fgraw_nxt [4];
  logic [C-1:0]  bg_r [3];
  logic [C-1:0]  bg_nxt [3];
  logic [C-1:0]  wv_r [4];
  logic [C-1:0]  wv_nxt [4];
  logic [7:0]    out8_r [4];
  logic [7:0]    out8_nxt [4];
  logic [7:0]    alpha_r, alpha_nxt;
  logic [YW-1:0] acc_r, acc_nxt;
  logic [YW-1:0] yb_r, yb_nxt;
  logic [YW-1:0] rhi_r, rhi_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [SS:0]   m_r, m_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic          black_r, black_nxt;
  logic          adj_r, adj_nxt, fell_r, fell_nxt;
  logic [L-1:0]  rom_q_r;
  logic [P_W-1:0] prod_r;

  logic [A_W-1:0]  mul_a;
  logic [B_W-1:0]  mul_b;
  logic [YW-1:0]   acc_sum, y_hi, y_lo;
  logic            ratio_pass;
  logic [MIXW-1:0] mix_sum, tgt_m;
  logic [C:0]      q0, q_fix;
  logic [NW:0]     q0_den, rem, den;
  logic [7:0]      inv_a;
  logic [SS:0]     lo_upd, hi_upd;

  assign busy      = (state_r != mcca_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_red   = out8_r[0];
  assign out_green = out8_r[1];
  assign out_blue  = out8_r[2];
  assign out_alpha = out8_r[3];
  assign out_adjusted  = adj_r;
  assign out_fell_back = fell_r;

  always_comb begin
    acc_sum    = acc_r + prod_r[YW-1:0];
    y_hi       = (acc_r > yb_r) ? acc_r : yb_r;
    y_lo       = (acc_r > yb_r) ? yb_r : acc_r;
    ratio_pass = (P_W'({rhi_r, 8'd0}) >= prod_r);
    tgt_m      = (ch_r == 2'd3 || !black_r) ? ((MIXW'(m_r) << C) - MIXW'(m_r)) : '0;
    mix_sum    = prod_r[MIXW-1:0] + tgt_m + HALF_W;
    inv_a      = 8'd255 - alpha_r;
    q0         = prod_r[DS +: C + 1];
    if (state_r == mcca_pkg::S_CMP_FIX) begin
      den    = (NW + 1)'(255);
      q0_den = ((NW + 1)'(q0) << 8) - (NW + 1)'(q0);
    end else begin
      den    = (NW + 1)'(C_MAX);
      q0_den = ((NW + 1)'(q0) << C) - (NW + 1)'(q0);
    end
    rem    = (NW + 1)'(n_r) - q0_den;
    q_fix  = q0 + (C + 1)'(rem >= den);
    lo_upd = ratio_pass ? lo_r : m_r;
    hi_upd = ratio_pass ? m_r : hi_r;
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    ch_nxt        = ch_r;
    step_nxt      = step_r;
    out_valid_nxt = 1'b0;
    min_ratio_nxt = min_ratio_r;
    dark_nxt      = dark_r;
    fg_nxt        = fg_r;
    fgraw_nxt     = fgraw_r;
    bg_nxt        = bg_r;
    wv_nxt        = wv_r;
    out8_nxt      = out8_r;
    alpha_nxt     = alpha_r;
    acc_nxt       = acc_r;
    yb_nxt        = yb_r;
    rhi_nxt       = rhi_r;
    n_nxt         = n_r;
    m_nxt         = m_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    black_nxt     = black_r;
    adj_nxt       = adj_r;
    fell_nxt      = fell_r;
    mul_a         = '0;
    mul_b         = '0;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mcca_pkg::CFG_MIN_RATIO:     min_ratio_nxt = cfg_data;
        mcca_pkg::CFG_DARK_BACKDROP: dark_nxt = cfg_data[0];
        default: ;
      endcase
    end

    unique case (state_r)
      mcca_pkg::S_IDLE: begin
        if (start) begin
          fgraw_nxt[0] = in_fg_red;
          fgraw_nxt[1] = in_fg_green;
          fgraw_nxt[2] = in_fg_blue;
          fgraw_nxt[3] = in_fg_alpha;
          fg_nxt[0] = EXP_TAB[in_fg_red];
          fg_nxt[1] = EXP_TAB[in_fg_green];
          fg_nxt[2] = EXP_TAB[in_fg_blue];
          fg_nxt[3] = EXP_TAB[in_fg_alpha];
          bg_nxt[0] = EXP_TAB[in_bg_red];
          bg_nxt[1] = EXP_TAB[in_bg_green];
          bg_nxt[2] = EXP_TAB[in_bg_blue];
          wv_nxt[0] = EXP_TAB[in_bg_red];
          wv_nxt[1] = EXP_TAB[in_bg_green];
          wv_nxt[2] = EXP_TAB[in_bg_blue];
          alpha_nxt = in_bg_alpha;
          phase_nxt = mcca_pkg::PH_BG;
          ch_nxt    = 2'd0;
          acc_nxt   = '0;
          state_nxt = mcca_pkg::S_LUM_RD;
        end
      end
      mcca_pkg::S_LUM_RD: begin
        state_nxt = mcca_pkg::S_LUM_MUL;
      end
      mcca_pkg::S_LUM_MUL: begin
        mul_a     = A_W'(rom_q_r);
        mul_b     = B_W'(mcca_pkg::luma_coef(ch_r));
        state_nxt = mcca_pkg::S_LUM_ACC;
      end
      mcca_pkg::S_LUM_ACC: begin
        acc_nxt = acc_sum;
        if (ch_r != 2'd2) begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = mcca_pkg::S_LUM_RD;
        end else begin
          ch_nxt = 2'd0;
          unique case (phase_r)
            mcca_pkg::PH_BG: begin
              yb_nxt    = acc_sum;
              wv_nxt[0] = fg_r[0];
              wv_nxt[1] = fg_r[1];
              wv_nxt[2] = fg_r[2];
              acc_nxt   = '0;
              phase_nxt = mcca_pkg::PH_FG;
              state_nxt = mcca_pkg::S_LUM_RD;
            end
            mcca_pkg::PH_EFF: begin
              black_nxt = (acc_sum > Y_THR);
              lo_nxt    = '0;
              hi_nxt    = W_FULL;
              m_nxt     = W_FULL >> 1;
              step_nxt  = '0;
              phase_nxt = mcca_pkg::PH_SRCH;
              state_nxt = mcca_pkg::S_MIX_MUL;
            end
            default: state_nxt = mcca_pkg::S_RAT_MUL;
          endcase
        end
      end
      mcca_pkg::S_RAT_MUL: begin
        mul_a     = A_W'(y_lo + Y_OFS);
        mul_b     = B_W'(min_ratio_r);
        rhi_nxt   = y_hi + Y_OFS;
        state_nxt = mcca_pkg::S_RAT_CMP;
      end
      mcca_pkg::S_RAT_CMP: begin
        ch_nxt = 2'd0;
        unique case (phase_r)
          mcca_pkg::PH_FG: begin
            if (ratio_pass) begin
              out8_nxt      = fgraw_r;
              adj_nxt       = 1'b0;
              fell_nxt      = 1'b0;
              out_valid_nxt = 1'b1;
              state_nxt     = mcca_pkg::S_IDLE;
            end else if (alpha_r == 8'd255) begin
              wv_nxt[0] = bg_r[0];
              wv_nxt[1] = bg_r[1];
              wv_nxt[2] = bg_r[2];
              acc_nxt   = '0;
              phase_nxt = mcca_pkg::PH_EFF;
              state_nxt = mcca_pkg::S_LUM_RD;
            end else begin
              phase_nxt = mcca_pkg::PH_EFF;
              state_nxt = mcca_pkg::S_CMP_MUL;
            end
          end
          mcca_pkg::PH_SRCH: begin
            lo_nxt    = lo_upd;
            hi_nxt    = hi_upd;
            state_nxt = mcca_pkg::S_MIX_MUL;
            if (step_r == STEP_W'(SS - 1)) begin
              m_nxt     = hi_upd;
              phase_nxt = mcca_pkg::PH_FINAL;
            end else begin
              m_nxt    = (lo_upd + hi_upd) >> 1;
              step_nxt = step_r + STEP_W'(1);
            end
          end
          mcca_pkg::PH_FINAL: begin
            if (ratio_pass) begin
              state_nxt = mcca_pkg::S_OUT_SUM;
            end else begin
              out8_nxt[0]   = black_r ? 8'd0 : 8'd255;
              out8_nxt[1]   = black_r ? 8'd0 : 8'd255;
              out8_nxt[2]   = black_r ? 8'd0 : 8'd255;
              out8_nxt[3]   = 8'd255;
              adj_nxt       = 1'b1;
              fell_nxt      = 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt     = mcca_pkg::S_IDLE;
            end
          end
          default: state_nxt = mcca_pkg::S_IDLE;
        endcase
      end
      mcca_pkg::S_CMP_MUL: begin
        mul_a     = A_W'(bg_r[ch_r]);
        mul_b     = B_W'(alpha_r);
        state_nxt = mcca_pkg::S_CMP_SUM;
      end
      mcca_pkg::S_CMP_SUM: begin
        n_nxt = prod_r[NW-1:0] + NW'(127);
        if (!dark_r) begin
          n_nxt = prod_r[NW-1:0] + NW'(127) + ((NW'(inv_a) << C) - NW'(inv_a));
        end
        state_nxt = mcca_pkg::S_CMP_DIV;
      end
      mcca_pkg::S_CMP_DIV: begin
        mul_a     = A_W'(n_r);
        mul_b     = R_255;
        state_nxt = mcca_pkg::S_CMP_FIX;
      end
      mcca_pkg::S_CMP_FIX: begin
        wv_nxt[ch_r] = q_fix[C-1:0];
        if (ch_r != 2'd2) begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = mcca_pkg::S_CMP_MUL;
        end else begin
          ch_nxt    = 2'd0;
          acc_nxt   = '0;
          state_nxt = mcca_pkg::S_LUM_RD;
        end
      end
      mcca_pkg::S_MIX_MUL: begin
        mul_a     = A_W'(W_FULL - m_r);
        mul_b     = B_W'(fg_r[ch_r]);
        state_nxt = mcca_pkg::S_MIX_FIX;
      end
      mcca_pkg::S_MIX_FIX: begin
        wv_nxt[ch_r] = mix_sum[SS +: C];
        if ((ch_r == 2'd3) || (ch_r == 2'd2 && phase_r != mcca_pkg::PH_FINAL)) begin
          ch_nxt    = 2'd0;
          acc_nxt   = '0;
          state_nxt = mcca_pkg::S_LUM_RD;
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = mcca_pkg::S_MIX_MUL;
        end
      end
      mcca_pkg::S_OUT_SUM: begin
        n_nxt     = (NW'(wv_r[ch_r]) << 8) - NW'(wv_r[ch_r]) + C_HALF;
        state_nxt = mcca_pkg::S_OUT_DIV;
      end
      mcca_pkg::S_OUT_DIV: begin
        mul_a     = A_W'(n_r);
        mul_b     = R_CMAX;
        state_nxt = mcca_pkg::S_OUT_FIX;
      end
      mcca_pkg::S_OUT_FIX: begin
        out8_nxt[ch_r] = q_fix[7:0];
        if (ch_r == 2'd3) begin
          ch_nxt        = 2'd0;
          adj_nxt       = 1'b1;
          fell_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = mcca_pkg::S_IDLE;
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = mcca_pkg::S_OUT_SUM;
        end
      end
      default: state_nxt = mcca_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcca_pkg::S_IDLE;
      phase_r     <= mcca_pkg::PH_BG;
      ch_r        <= 2'd0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      min_ratio_r <= mcca_pkg::MIN_RATIO_RST;
      dark_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      ch_r        <= ch_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      min_ratio_r <= min_ratio_nxt;
      dark_r      <= dark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fg_r    <= fg_nxt;
    fgraw_r <= fgraw_nxt;
    bg_r    <= bg_nxt;
    wv_r    <= wv_nxt;
    out8_r  <= out8_nxt;
    alpha_r <= alpha_nxt;
    acc_r   <= acc_nxt;
    yb_r    <= yb_nxt;
    rhi_r   <= rhi_nxt;
    n_r     <= n_nxt;
    m_r     <= m_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    black_r <= black_nxt;
    adj_r   <= adj_nxt;
    fell_r  <= fell_nxt;
    prod_r  <= mul_a * mul_b;
    rom_q_r <= LIN_ROM[wv_r[ch_r]];
  end

  `MCCA_ASSERT_IMP(a_valid_idle, out_valid_r, state_r == mcca_pkg::S_IDLE)
  `MCCA_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `MCCA_ASSERT_IMP(a_fell_adj, out_valid_r && fell_r, adj_r)
  `MCCA_ASSERT_IMP(a_fell_gray, out_valid_r && fell_r, out8_r[3] == 8'd255 && out8_r[0] == out8_r[1] && out8_r[1] == out8_r[2])
  `MCCA_ASSERT_IMP(a_search_lohi, phase_r == mcca_pkg::PH_SRCH && state_r == mcca_pkg::S_MIX_MUL, lo_r <= m_r && m_r <= hi_r)

endmodule

FILE: test/min_contrast_color_adjust_tb.sv
// Testbench for min_contrast_color_adjust: directed and random color pairs against a local predictor.
`timescale 1ns / 100ps
module min_contrast_color_adjust_tb;

  localparam longint unsigned CMAX  = 4095;
  localparam longint unsigned LMAX  = 65535;
  localparam longint unsigned QONE  = 64'd1 << 30;
  localparam int              STEPS = 24;
  localparam longint unsigned WFULL = 64'd1 << STEPS;
  localparam logic [mcca_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [mcca_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam longint unsigned CYCLE_LIMIT = 3000000;
  localparam int SETTLE = 600;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       adjusted;
    logic       fell_back;
  } color_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [7:0] in_fg_red = '0, in_fg_green = '0, in_fg_blue = '0, in_fg_alpha = '0;
  logic [7:0] in_bg_red = '0, in_bg_green = '0, in_bg_blue = '0, in_bg_alpha = '0;
  logic out_valid;
  logic [7:0] out_red, out_green, out_blue, out_alpha;
  logic out_adjusted, out_fell_back;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mcca_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mcca_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  min_contrast_color_adjust dut (.*);

  longint unsigned linear_lut [0:4095];
  longint unsigned req_ratio;
  logic            black_backdrop;
  color_result_t   pending_colors [$];
  int              mismatches = 0;
  longint unsigned cycles = 0;
  int              gap_pct = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned pow5_q30(longint unsigned r);
    longint unsigned r2, r4;
    r2 = (r * r) >> 30;
    r4 = (r2 * r2) >> 30;
    return (r4 * r) >> 30;
  endfunction

  function automatic longint unsigned linearize(longint unsigned v);
    longint unsigned t, t2, lo, hi, mid;
    if (v * 100000 <= 3928 * CMAX) return (v * 100 * LMAX) / (1292 * CMAX);
    t = ((1000 * v + 55 * CMAX) << 30) / (1055 * CMAX);
    if (t > QONE) t = QONE;
    t2 = (t * t) >> 30;
    lo = 0;
    hi = QONE + 1;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (pow5_q30(mid) <= t2) lo = mid;
      else hi = mid;
    end
    return (((t2 * lo) >> 30) * LMAX) >> 30;
  endfunction

  function automatic longint unsigned luminance(longint unsigned r, longint unsigned g,
                                                longint unsigned b);
    return 2126 * linear_lut[r] + 7152 * linear_lut[g] + 722 * linear_lut[b];
  endfunction

  function automatic bit contrast_ok(longint unsigned ya, longint unsigned yb);
    longint unsigned hi, lo;
    hi = ya > yb ? ya : yb;
    lo = ya > yb ? yb : ya;
    return (hi + 500 * LMAX) * 256 >= req_ratio * (lo + 500 * LMAX);
  endfunction

  function automatic longint unsigned widen(logic [7:0] x);
    return (longint'(x) * CMAX + 127) / 255;
  endfunction

  function automatic longint unsigned blend(longint unsigned f, longint unsigned g,
                                            longint unsigned m);
    return (f * (WFULL - m) + g * m + WFULL / 2) >> STEPS;
  endfunction

  function automatic color_result_t adjust_color(logic [7:0] fr, logic [7:0] fgc,
      logic [7:0] fb, logic [7:0] fa, logic [7:0] br, logic [7:0] bgc, logic [7:0] bb,
      logic [7:0] ba);
    color_result_t res;
    longint unsigned f [4];
    longint unsigned b [3];
    longint unsigned e [3];
    longint unsigned mx [4];
    longint unsigned yb, back, tv, lo, hi, m;
    bit dark;
    f[0] = widen(fr); f[1] = widen(fgc); f[2] = widen(fb); f[3] = widen(fa);
    b[0] = widen(br); b[1] = widen(bgc); b[2] = widen(bb);
    yb = luminance(b[0], b[1], b[2]);
    if (contrast_ok(luminance(f[0], f[1], f[2]), yb)) begin
      res = '{fr, fgc, fb, fa, 1'b0, 1'b0};
      return res;
    end
    back = black_backdrop ? 0 : CMAX;
    for (int i = 0; i < 3; i++)
      e[i] = (ba == 8'd255) ? b[i] : (b[i] * ba + back * (255 - ba) + 127) / 255;
    dark = luminance(e[0], e[1], e[2]) > 1790 * LMAX;
    tv = dark ? 0 : CMAX;
    lo = 0;
    hi = WFULL;
    for (int s = 0; s <= STEPS; s++) begin
      m = (s == STEPS) ? hi : (lo + hi) / 2;
      for (int i = 0; i < 3; i++) mx[i] = blend(f[i], tv, m);
      mx[3] = blend(f[3], CMAX, m);
      if (s == STEPS) break;
      if (contrast_ok(luminance(mx[0], mx[1], mx[2]), yb)) hi = m;
      else lo = m;
    end
    if (contrast_ok(luminance(mx[0], mx[1], mx[2]), yb)) begin
      res.red   = 8'((mx[0] * 255 + CMAX / 2) / CMAX);
      res.green = 8'((mx[1] * 255 + CMAX / 2) / CMAX);
      res.blue  = 8'((mx[2] * 255 + CMAX / 2) / CMAX);
      res.alpha = 8'((mx[3] * 255 + CMAX / 2) / CMAX);
      res.adjusted = 1'b1;
      res.fell_back = 1'b0;
    end else begin
      res = dark ? '{8'd0, 8'd0, 8'd0, 8'd255, 1'b1, 1'b1}
                 : '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1};
    end
    return res;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic check_field(string name, logic [7:0] expv, logic [7:0] got);
    if (expv !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    color_result_t want;
    if (rst_n && out_valid) begin
      if (pending_colors.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %0d %0d %0d %0d",
                 $time, out_red, out_green, out_blue, out_alpha);
        mismatches++;
      end else begin
        want = pending_colors.pop_front();
        check_field("red", want.red, out_red);
        check_field("green", want.green, out_green);
        check_field("blue", want.blue, out_blue);
        check_field("alpha", want.alpha, out_alpha);
        check_field("adjusted", 8'(want.adjusted), 8'(out_adjusted));
        check_field("fell_back", 8'(want.fell_back), 8'(out_fell_back));
      end
    end
  end

  task automatic send_colors(logic [7:0] fr, logic [7:0] fgc, logic [7:0] fb,
      logic [7:0] fa, logic [7:0] br, logic [7:0] bgc, logic [7:0] bb, logic [7:0] ba);
    if ($urandom_range(99) < gap_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
    {in_fg_red, in_fg_green, in_fg_blue, in_fg_alpha} = {fr, fgc, fb, fa};
    {in_bg_red, in_bg_green, in_bg_blue, in_bg_alpha} = {br, bgc, bb, ba};
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_colors.push_back(adjust_color(fr, fgc, fb, fa, br, bgc, bb, ba));
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending_colors.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [mcca_pkg::CFG_IDX_W-1:0] idx,
                           logic [mcca_pkg::CFG_DATA_W-1:0] val);
    drain();
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    if (idx == mcca_pkg::CFG_MIN_RATIO) req_ratio = val;
    else if (idx == mcca_pkg::CFG_DARK_BACKDROP) black_backdrop = val[0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_directed();
    send_colors(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_colors(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_colors(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    send_colors(8'd128, 8'd128, 8'd128, 8'd0, 8'd118, 8'd118, 8'd118, 8'd255);
    send_colors(8'd200, 8'd30, 8'd90, 8'd77, 8'd180, 8'd40, 8'd100, 8'd0);
    send_colors(8'd10, 8'd12, 8'd9, 8'd255, 8'd20, 8'd20, 8'd20, 8'd128);
    send_colors(8'd119, 8'd119, 8'd119, 8'd255, 8'd119, 8'd119, 8'd119, 8'd1);
    send_colors(8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd254);
  endtask

  task automatic test_ratio_extremes();
    write_reg(mcca_pkg::CFG_MIN_RATIO, 13'd0);
    send_colors(8'd50, 8'd50, 8'd50, 8'd255, 8'd50, 8'd50, 8'd50, 8'd255);
    write_reg(mcca_pkg::CFG_MIN_RATIO, 13'd256);
    send_colors(8'd50, 8'd50, 8'd50, 8'd255, 8'd50, 8'd50, 8'd50, 8'd255);
    write_reg(mcca_pkg::CFG_MIN_RATIO, 13'd5376);
    send_colors(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_colors(8'd90, 8'd90, 8'd90, 8'd40, 8'd255, 8'd255, 8'd255, 8'd255);
    write_reg(mcca_pkg::CFG_MIN_RATIO, 13'd8191);
    send_colors(8'd90, 8'd90, 8'd90, 8'd40, 8'd255, 8'd255, 8'd255, 8'd255);
    send_colors(8'd90, 8'd90, 8'd90, 8'd40, 8'd10, 8'd10, 8'd10, 8'd255);
    write_reg(mcca_pkg::CFG_DARK_BACKDROP, 13'd1);
    send_colors(8'd150, 8'd150, 8'd150, 8'd200, 8'd150, 8'd150, 8'd150, 8'd60);
    write_reg(mcca_pkg::CFG_MIN_RATIO, 13'd1152);
    send_colors(8'd150, 8'd150, 8'd150, 8'd200, 8'd150, 8'd150, 8'd150, 8'd60);
    send_colors(8'd150, 8'd150, 8'd150, 8'd200, 8'd150, 8'd150, 8'd150, 8'd0);
  endtask

  task automatic test_spare_index();
    logic [mcca_pkg::CFG_DATA_W-1:0] keep_ratio;
    logic                            keep_dark;
    keep_ratio = req_ratio[12:0];
    keep_dark = black_backdrop;
    write_reg(CFG_SPARE_A, 13'h1FFF);
    write_reg(CFG_SPARE_B, 13'h0000);
    req_ratio = keep_ratio;
    black_backdrop = keep_dark;
    send_colors(8'd100, 8'd110, 8'd120, 8'd255, 8'd130, 8'd140, 8'd150, 8'd255);
    send_colors(8'd100, 8'd110, 8'd120, 8'd255, 8'd130, 8'd140, 8'd150, 8'd100);
  endtask

  task automatic test_random(int count, int pct);
    logic [7:0] fr, fgc, fb, fa, br, bgc, bb, ba;
    gap_pct = pct;
    for (int n = 0; n < count; n++) begin
      {fr, fgc, fb, fa} = $urandom;
      {br, bgc, bb} = 24'($urandom);
      case ($urandom_range(3))
        0: ba = 8'($urandom);
        1: ba = 8'd255;
        2: ba = 8'd255;
        default: ba = $urandom_range(1) ? 8'd0 : 8'd254;
      endcase
      if ($urandom_range(4) == 0) begin
        bgc = fgc + 8'($urandom_range(20));
        br = fr;
      end
      if (n == count / 2 && pct > 0) drain();
      send_colors(fr, fgc, fb, fa, br, bgc, bb, ba);
    end
    gap_pct = 0;
  endtask

  initial begin
    for (int v = 0; v <= 4095; v++) linear_lut[v] = linearize(v);
    req_ratio = 1152;
    black_backdrop = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_ratio_extremes();
    test_spare_index();
    test_random(350, 0);
    write_reg(mcca_pkg::CFG_MIN_RATIO, 13'($urandom_range(256, 5376)));
    write_reg(mcca_pkg::CFG_DARK_BACKDROP, 13'd0);
    test_random(350, 50);
    write_reg(mcca_pkg::CFG_MIN_RATIO, 13'd1792);
    write_reg(mcca_pkg::CFG_DARK_BACKDROP, 13'd1);
    test_random(350, 0);
    write_reg(mcca_pkg::CFG_MIN_RATIO, 13'($urandom_range(256, 5376)));
    test_random(330, 8);
    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+sv
sv/mcca_pkg.sv
sv/min_contrast_color_adjust.sv
test/min_contrast_color_adjust_tb.sv
